[design/rcfp_pkg.sv]
// shared constants and the crc-8 step for the channel frame packer
// no dependencies; compiled first
package rcfp_pkg;

  localparam int PULSE_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int CH_W      = 11;
  localparam int CFG_IDX_W = 1;

  // scaling: value = center + trunc(pulse * 4 / 5), clamped to 0 .. 2 * center
  localparam logic [CH_W-1:0] CH_CENTER  = 11'h3E0;
  localparam logic [CH_W-1:0] MAG_LIMIT  = 11'd1240;  // 4 * 1240 / 5 == center
  localparam logic [15:0]     RECIP_FIVE = 16'd52429; // ceil(2^18 / 5)
  localparam int              RECIP_SHIFT = 18;

  localparam logic [3:0]        CH_LAST        = 4'd15;
  localparam logic [BYTE_W-1:0] FRAME_LEN_BYTE = 8'd24;
  localparam logic [BYTE_W-1:0] CRC_POLY       = 8'hD5;

  localparam logic [BYTE_W-1:0] ADDR_RESET = 8'd200;
  localparam logic [BYTE_W-1:0] TYPE_RESET = 8'd22;

  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE     = 1'b1;

  // msb-first crc-8 over one byte
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/rcfp_channels.sv]
// valid/ready channel interfaces: pulse items in, frame bytes out
// depends on rcfp_pkg for field widths
interface rcfp_pulse_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcfp_pkg::PULSE_W-1:0]  pulse;

  modport source (output valid, output pulse, input ready);
  modport sink   (input valid, input pulse, output ready);
endinterface

interface rcfp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [rcfp_pkg::BYTE_W-1:0]   frame_byte;
  logic                          last_of_item;
  logic                          frame_end;

  modport source (output valid, output frame_byte, output last_of_item, output frame_end,
                  input ready);
  modport sink   (input valid, input frame_byte, input last_of_item, input frame_end,
                  output ready);
endinterface

[design/rcfp_scale.sv]
// pulse to 11-bit channel value: center + trunc(4p/5), clamped
// depends on rcfp_pkg
module rcfp_scale (
  input  logic signed [rcfp_pkg::PULSE_W-1:0] pulse,
  output logic        [rcfp_pkg::CH_W-1:0]    value
);
  import rcfp_pkg::*;

  logic                  neg;
  logic [PULSE_W:0]      mag;
  logic [CH_W-1:0]       mag_c;
  logic [CH_W+1:0]       x4;
  logic [CH_W+17:0]      prod;
  logic [CH_W-1:0]       quot;

  assign neg   = pulse[PULSE_W-1];
  assign mag   = neg ? ((PULSE_W+1)'(0) - {pulse[PULSE_W-1], pulse}) : {1'b0, pulse};
  // clamp before dividing; beyond the limit the result saturates anyway
  assign mag_c = (mag > {{(PULSE_W+1-CH_W){1'b0}}, MAG_LIMIT}) ? MAG_LIMIT : mag[CH_W-1:0];
  assign x4    = {mag_c, 2'b00};
  // x4 < 2^18 so multiply by ceil(2^18/5) and shift gives the exact floor
  assign prod  = x4 * RECIP_FIVE;
  assign quot  = prod[RECIP_SHIFT +: CH_W];
  assign value = neg ? (CH_CENTER - quot) : (CH_CENTER + quot);

endmodule

[design/rc_channel_frame_packer_unit.sv]
// top level of the radio-control channel frame packer
// depends on rcfp_pkg, rcfp_channels (interfaces) and rcfp_scale
//
// each accepted pulse is one channel; sixteen channels make one 26-byte frame:
// address, length 24, type, 22 bytes of 11-bit channel values packed lsb-first,
// and a crc-8 (poly 0xd5, init 0) over type and payload. a pulse goes into an
// input register; once the output buffer is empty or its last byte leaves,
// the scaled value is packed and its bytes are loaded into a 4-slot output
// buffer, which drives one byte per cycle while the receiver is ready. an item
// fills 4 bytes (first channel), 3 bytes (last channel) or 1 to 2 bytes
// (others), 26 bytes per frame of 16 items; the single byte-wide output port
// sets the pace. the next item is loaded in the cycle the previous item's last
// byte is transferred, so bytes stream without gaps while pulses keep up.
// the crc is kept on the output side, updated on type and payload bytes only.
// register writes are expected only while the block is idle.
module rc_channel_frame_packer_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rcfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcfp_pkg::BYTE_W-1:0]       cfg_data,
  rcfp_pulse_if.sink                        chan,
  rcfp_byte_if.source                       frame
);
  import rcfp_pkg::*;

  // role of each buffered byte on the output side
  typedef enum logic [1:0] {
    KIND_ADDR,   // frame start, clears the crc
    KIND_LEN,    // not covered by the crc
    KIND_DATA,   // covered by the crc
    KIND_CRC     // replaced by the running crc
  } kind_t;

  // configuration registers
  logic [BYTE_W-1:0]  device_address;
  logic [BYTE_W-1:0]  frame_type;

  // input register
  logic                       in_vld;
  logic signed [PULSE_W-1:0]  in_pulse;

  // packing state
  logic [6:0]  acc;       // leftover packed bits, at most 7
  logic [2:0]  held;
  logic [3:0]  ch_cnt;

  // output buffer
  logic [BYTE_W-1:0]  slot_byte [4];
  kind_t              slot_kind [4];
  logic [1:0]         last_idx;
  logic [1:0]         idx;
  logic               buf_vld;
  logic [BYTE_W-1:0]  crc;

  // load side
  logic [CH_W-1:0]    scaled;
  logic               ch_first;
  logic               ch_final;
  logic [6:0]         acc_in;
  logic [2:0]         held_in;
  logic [17:0]        combined;
  logic [4:0]         total;
  logic               two_bytes;
  logic [6:0]         acc_next;
  logic [BYTE_W-1:0]  ld_byte [4];
  kind_t              ld_kind [4];
  logic [1:0]         ld_last;

  // output side
  logic               out_xfer;
  logic               at_last;
  logic               load;
  kind_t              cur_kind;

  rcfp_scale u_scale (
    .pulse (in_pulse),
    .value (scaled)
  );

  // ---------------------------------------------------------------------------
  // packing of one channel value
  // ---------------------------------------------------------------------------
  assign ch_first  = (ch_cnt == 4'd0);
  assign ch_final  = (ch_cnt == CH_LAST);
  // a new frame starts with an empty accumulator
  assign acc_in    = ch_first ? 7'd0 : acc;
  assign held_in   = ch_first ? 3'd0 : held;
  assign combined  = {11'd0, acc_in} | ({7'd0, scaled} << held_in);
  assign total     = {2'b00, held_in} + 5'(CH_W);
  assign two_bytes = total[4];
  assign acc_next  = two_bytes ? {5'd0, combined[17:16]} : combined[14:8];

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      ld_byte[s] = '0;
      ld_kind[s] = KIND_DATA;
    end
    ld_last = 2'd0;
    if (ch_first) begin
      // header plus the one payload byte of the first channel
      ld_byte[0] = device_address;
      ld_kind[0] = KIND_ADDR;
      ld_byte[1] = FRAME_LEN_BYTE;
      ld_kind[1] = KIND_LEN;
      ld_byte[2] = frame_type;
      ld_byte[3] = combined[7:0];
      ld_last    = 2'd3;
    end else begin
      ld_byte[0] = combined[7:0];
      ld_byte[1] = combined[15:8];
      ld_last    = two_bytes ? 2'd1 : 2'd0;
      if (ch_final) begin
        // crc goes right after the last payload byte
        if (two_bytes) begin
          ld_kind[2] = KIND_CRC;
          ld_last    = 2'd2;
        end else begin
          ld_kind[1] = KIND_CRC;
          ld_last    = 2'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign out_xfer   = buf_vld && frame.ready;
  assign at_last    = (idx == last_idx);
  // buffer takes the next item when empty or as its final byte leaves
  assign load       = in_vld && (!buf_vld || (out_xfer && at_last));
  assign chan.ready = !in_vld || load;

  assign cur_kind           = slot_kind[idx];
  assign frame.valid        = buf_vld;
  assign frame.frame_byte   = (cur_kind == KIND_CRC) ? crc : slot_byte[idx];
  assign frame.last_of_item = at_last;
  assign frame.frame_end    = (cur_kind == KIND_CRC);

  // ---------------------------------------------------------------------------
  // control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      frame_type     <= TYPE_RESET;
      in_vld         <= 1'b0;
      acc            <= '0;
      held           <= '0;
      ch_cnt         <= '0;
      idx            <= '0;
      buf_vld        <= 1'b0;
      crc            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS: device_address <= cfg_data;
          REG_FRAME_TYPE:     frame_type     <= cfg_data;
          default: ;
        endcase
      end

      if (chan.valid && chan.ready) begin
        in_vld <= 1'b1;
      end else if (load) begin
        in_vld <= 1'b0;
      end

      if (load) begin
        acc     <= acc_next;
        held    <= total[2:0];
        ch_cnt  <= ch_cnt + 4'd1;
        idx     <= 2'd0;
        buf_vld <= 1'b1;
      end else if (out_xfer) begin
        if (at_last) begin
          buf_vld <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end

      // running crc follows the bytes in transfer order
      if (out_xfer) begin
        case (cur_kind)
          KIND_ADDR: crc <= '0;
          KIND_DATA: crc <= crc8_step(crc, slot_byte[idx]);
          default:   crc <= crc;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (chan.valid && chan.ready) begin
      in_pulse <= chan.pulse;
    end
    if (load) begin
      for (int s = 0; s < 4; s++) begin
        slot_byte[s] <= ld_byte[s];
        slot_kind[s] <= ld_kind[s];
      end
      last_idx <= ld_last;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    buf_vld |-> (idx <= last_idx))
    else $error("output slot index beyond last loaded slot");

  a_crc_closes_item: assert property (@(posedge clk) disable iff (rst)
    (buf_vld && frame.frame_end) |-> at_last)
    else $error("crc byte is not the final byte of its item");

  a_frame_aligned: assert property (@(posedge clk) disable iff (rst)
    (load && ch_final) |=> (held == 3'd0 && acc == 7'd0 && ch_cnt == 4'd0))
    else $error("packing state not byte aligned after last channel");

endmodule

[tb/sv/rc_channel_frame_packer_unit_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for rc_channel_frame_packer_unit: channel pulses in, frame bytes out
// depends on rcfp_pkg and the rcfp_channels interfaces; an embedded class predicts every byte
module rc_channel_frame_packer_unit_test;
  import rcfp_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  // long receiver hold-off used to back the block up into its input
  localparam int HOLD_OFF   = 80;

  // one byte of the outgoing frame as seen on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last_of_item;
    logic              frame_end;
  } frame_byte_t;

  // predicts the frame bytes each channel pulse causes and checks the output against them
  class channel_frame_tracker;
    logic [BYTE_W-1:0] address_reg;
    logic [BYTE_W-1:0] type_reg;
    logic [17:0]       bit_acc;
    int                bit_cnt;
    logic [3:0]        chan_idx;
    logic [BYTE_W-1:0] crc_acc;
    frame_byte_t       expected_bytes[$];
    int                errors;

    function new();
      address_reg = ADDR_RESET;
      type_reg    = TYPE_RESET;
      bit_acc     = '0;
      bit_cnt     = 0;
      chan_idx    = '0;
      crc_acc     = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      if (idx == REG_DEVICE_ADDRESS) begin
        address_reg = val;
      end else if (idx == REG_FRAME_TYPE) begin
        type_reg = val;
      end
    endfunction

    // crc-8, msb first
    function logic [BYTE_W-1:0] crc_next(logic [BYTE_W-1:0] crc, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = crc ^ b;
      repeat (BYTE_W) begin
        r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      end
      return r;
    endfunction

    // center + trunc(p * 4 / 5), saturated to 0 .. 2 * center
    function logic [CH_W-1:0] scaled(logic signed [PULSE_W-1:0] p);
      int v;
      v = int'(CH_CENTER) + (int'(p) * 4) / 5;
      if (v < 0) v = 0;
      if (v > 2 * int'(CH_CENTER)) v = 2 * int'(CH_CENTER);
      return v[CH_W-1:0];
    endfunction

    function void note_pulse(logic signed [PULSE_W-1:0] p);
      logic [CH_W-1:0] v;
      int total;
      int npack;
      int i;
      v = scaled(p);
      // frame start: header bytes, crc seeded with the type byte
      if (chan_idx == 4'd0) begin
        bit_acc = '0;
        bit_cnt = 0;
        expected_bytes.push_back('{address_reg, 1'b0, 1'b0});
        expected_bytes.push_back('{FRAME_LEN_BYTE, 1'b0, 1'b0});
        expected_bytes.push_back('{type_reg, 1'b0, 1'b0});
        crc_acc = crc_next('0, type_reg);
      end
      bit_acc = bit_acc | (18'(v) << bit_cnt);
      total   = bit_cnt + CH_W;
      npack   = total / 8;
      for (i = 0; i < npack; i++) begin
        expected_bytes.push_back('{bit_acc[7:0], (i == npack - 1) && (chan_idx != CH_LAST),
                                   1'b0});
        crc_acc = crc_next(crc_acc, bit_acc[7:0]);
        bit_acc = bit_acc >> 8;
      end
      bit_cnt = total % 8;
      if (chan_idx == CH_LAST) begin
        expected_bytes.push_back('{crc_acc, 1'b1, 1'b1});
      end
      chan_idx = chan_idx + 4'd1;
    endfunction

    function void check_byte(frame_byte_t got);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame byte %h (last_of_item %b, frame_end %b)",
                 $time, got.data, got.last_of_item, got.frame_end);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data != want.data) begin
        errors++;
        $display("%0t: frame_byte expected %h actual %h", $time, want.data, got.data);
      end
      if (got.last_of_item != want.last_of_item) begin
        errors++;
        $display("%0t: last_of_item expected %b actual %b (byte %h)",
                 $time, want.last_of_item, got.last_of_item, want.data);
      end
      if (got.frame_end != want.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %b actual %b (byte %h)",
                 $time, want.frame_end, got.frame_end, want.data);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  rcfp_pulse_if chan_if ();
  rcfp_byte_if  frame_if ();

  rc_channel_frame_packer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .chan      (chan_if.sink),
    .frame     (frame_if.source)
  );

  channel_frame_tracker tracker = new();

  // per-pulse (sender) and per-byte (receiver) gap limits; zero gives back-to-back streaming
  int tx_gap_max     = 10;
  int rx_gap_max     = 10;
  // a one-shot long hold-off that the receiver picks up on its next byte
  int rx_hold_cycles = 0;
  int idle_cycles    = 0;

  // pulses aimed at the saturation points, rounding toward zero and every input bit
  logic signed [PULSE_W-1:0] corner_pulses [20] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1024, 16'sd1024,
    16'sd1240, -16'sd1240, 16'sd1241, -16'sd1241, 16'sd1,
    -16'sd1, 16'sd4, -16'sd4, 16'sd5, -16'sd5,
    16'sh5555, -16'sh5556, 16'sd2, -16'sd2, 16'sd617
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------

  // offer one pulse after a random gap and note it once the transfer happens;
  // with no gap valid simply stays high from the previous transfer
  task automatic send_pulse(input logic signed [PULSE_W-1:0] p);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chan_if.valid <= 1'b1;
    chan_if.pulse <= p;
    do @(posedge clk); while (!chan_if.ready);
    tracker.note_pulse(p);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // stop offering, wait for every predicted byte, then let the pipeline settle
  task automatic drain_block(input int settle);
    chan_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // mostly nominal pulses, some around the clamp points, a few over the whole range
  function automatic logic signed [PULSE_W-1:0] random_pulse();
    int sel;
    int edge_val;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      return PULSE_W'(int'($urandom_range(0, 2600)) - 1300);
    end else if (sel < 9) begin
      edge_val = (sel == 7) ? 1240 : -1240;
      return PULSE_W'(edge_val + int'($urandom_range(0, 20)) - 10);
    end
    return PULSE_W'($urandom);
  endfunction

  task automatic random_phase(input int count, input int pause_at);
    int i;
    for (i = 0; i < count; i++) begin
      // sender goes quiet until the output has caught up completely
      if (i == pause_at) drain_block(0);
      send_pulse(random_pulse());
    end
  endtask

  // ------------------------------------------------------------------
  // receiver: random ready gaps, one long hold-off on request
  // ------------------------------------------------------------------
  initial begin
    int gap;
    frame_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_gap_max);
      end
      if (gap > 0) begin
        frame_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_if.ready <= 1'b1;
      do @(posedge clk); while (!frame_if.valid);
    end
  end

  // ------------------------------------------------------------------
  // output monitor and hang watchdog
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready) begin
      tracker.check_byte('{frame_if.frame_byte, frame_if.last_of_item, frame_if.frame_end});
    end
  end

  always @(posedge clk) begin
    if (rst || (chan_if.valid && chan_if.ready) || (frame_if.valid && frame_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_DEVICE_ADDRESS;
    cfg_data      <= '0;
    chan_if.valid <= 1'b0;
    chan_if.pulse <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner pulses at reset register values; 20 items run into a second frame
    foreach (corner_pulses[k]) send_pulse(corner_pulses[k]);
    drain_block(4);

    // all-ones registers, written mid-frame; random gaps on both sides
    write_reg(REG_DEVICE_ADDRESS, 8'hFF);
    write_reg(REG_FRAME_TYPE, 8'hFF);
    random_phase(35, 20);
    drain_block(4);

    // all-zero registers; receiver stalls long while the sender streams
    write_reg(REG_DEVICE_ADDRESS, 8'h00);
    write_reg(REG_FRAME_TYPE, 8'h00);
    tx_gap_max     = 0;
    rx_hold_cycles = HOLD_OFF;
    random_phase(35, -1);
    drain_block(4);

    // random registers, no idling on either side
    write_reg(REG_DEVICE_ADDRESS, BYTE_W'($urandom));
    write_reg(REG_FRAME_TYPE, BYTE_W'($urandom));
    rx_gap_max = 0;
    random_phase(35, -1);
    drain_block(4);

    // back to the reset values with random gaps again
    write_reg(REG_DEVICE_ADDRESS, ADDR_RESET);
    write_reg(REG_FRAME_TYPE, TYPE_RESET);
    tx_gap_max = 10;
    rx_gap_max = 10;
    random_phase(35, 30);
    drain_block(10);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
